// ===== hdl/qscp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qscp_pkg
// Shared types, character codes and key tables for the query string parser.
// ----------------------------------------------------------------------------
package qscp_pkg;

    localparam int NUM_KEYS = 7;
    localparam int KEY_TEXT_BITS = 88;

    localparam logic [2:0] K_PIN    = 3'd0;
    localparam logic [2:0] K_EFFECT = 3'd1;
    localparam logic [2:0] K_BRIGHT = 3'd2;
    localparam logic [2:0] K_VAR0   = 3'd3;
    localparam logic [2:0] K_VAR1   = 3'd4;
    localparam logic [2:0] K_VAR2   = 3'd5;
    localparam logic [2:0] K_SAVE   = 3'd6;
    localparam logic [2:0] KEY_NONE = 3'd7;

    localparam logic [7:0] CH_QUERY = 8'h3F;
    localparam logic [7:0] CH_EQUAL = 8'h3D;
    localparam logic [7:0] CH_AMP   = 8'h26;

    // Strings sit right-justified; character 0 is the most significant byte in use.
    localparam logic [KEY_TEXT_BITS-1:0] KEY_TEXT [NUM_KEYS] = '{
        KEY_TEXT_BITS'("pin"),
        KEY_TEXT_BITS'("effect"),
        KEY_TEXT_BITS'("brightness"),
        KEY_TEXT_BITS'("var0"),
        KEY_TEXT_BITS'("var1"),
        KEY_TEXT_BITS'("var2"),
        KEY_TEXT_BITS'("savesetting")
    };
    localparam logic [3:0] KEY_LEN [NUM_KEYS] = '{
        4'd3, 4'd6, 4'd10, 4'd4, 4'd4, 4'd4, 4'd11
    };

    localparam int FIND_LEN = 7;
    localparam logic [8*FIND_LEN-1:0] FIND_WORD = "EspFind";

    typedef enum logic [1:0] {
        KIND_IGNORED   = 2'd0,
        KIND_APPLIED   = 2'd1,
        KIND_REJECTED  = 2'd2,
        KIND_DISCOVERY = 2'd3
    } kind_t;

    typedef struct packed {
        logic [7:0] packet_byte;
        logic       last_byte;
    } qscp_in_t;

    typedef struct packed {
        kind_t       packet_kind;
        logic [15:0] received_pin;
        logic [15:0] effect_number;
        logic [15:0] brightness_level;
        logic [15:0] variable_zero;
        logic [15:0] variable_one;
        logic [15:0] variable_two;
        logic        save_request;
    } qscp_out_t;

    // Character idx of key k, or zero past the key's end (never alphanumeric).
    function automatic logic [7:0] key_char(input logic [2:0] k, input logic [3:0] idx);
        logic [7:0] ch;
        ch = 8'h00;
        if (idx < KEY_LEN[k])
        begin
            ch = KEY_TEXT[k][8*(int'(KEY_LEN[k]) - 1 - int'(idx)) +: 8];
        end
        return ch;
    endfunction

    function automatic logic [7:0] find_char(input logic [2:0] p);
        return FIND_WORD[8*(FIND_LEN - 1 - int'(p)) +: 8];
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return is_digit(c) || ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic is_delim(input logic [7:0] c);
        return (c == CH_QUERY) || (c == CH_EQUAL) || (c == CH_AMP);
    endfunction

endpackage
`default_nettype wire

// ===== hdl/qscp_stream_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qscp_stream_if
// Valid/ready channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface qscp_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/qscp_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qscp_parser
// Per-byte tokeniser state and the end-of-packet verdict logic.
// ----------------------------------------------------------------------------
module qscp_parser
    import qscp_pkg::*;
#(
    parameter int MAX_PAIRS  = 7,
    parameter int VALUE_BITS = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire qscp_in_t    beat,
    input  wire logic [15:0] access_pin,
    output qscp_out_t        result
);

    localparam int TOK_BITS = $clog2(2*MAX_PAIRS + 1);
    localparam logic [TOK_BITS-1:0] TOK_LIMIT = TOK_BITS'(2*MAX_PAIRS);
    localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;

    logic [3:0]            pos_reg, pos_next;
    logic                  disc_reg, disc_next;
    logic [TOK_BITS-1:0]   tok_reg, tok_next;
    logic                  stop_reg, stop_next;
    logic [3:0]            kidx_reg, kidx_next;
    logic [NUM_KEYS-1:0]   kmatch_reg, kmatch_next;
    logic [2:0]            active_reg, active_next;
    logic [VALUE_BITS-1:0] acc_reg, acc_next;
    logic                  done_reg, done_next;
    logic [NUM_KEYS-1:0]   found_reg, found_next;
    logic [VALUE_BITS-1:0] value_reg  [NUM_KEYS];
    logic [VALUE_BITS-1:0] value_next [NUM_KEYS];
    logic [VALUE_BITS-1:0] final_val  [NUM_KEYS];
    logic [31:0]           wide_val   [NUM_KEYS];

    logic [7:0]            c;
    logic [VALUE_BITS+3:0] prod;
    logic                  found_word;

    assign c = beat.packet_byte;
    assign prod = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                + {(VALUE_BITS)'(0), c[3:0]};

    always_comb
    begin
        pos_next    = pos_reg;
        disc_next   = disc_reg;
        tok_next    = tok_reg;
        stop_next   = stop_reg;
        kidx_next   = kidx_reg;
        kmatch_next = kmatch_reg;
        active_next = active_reg;
        acc_next    = acc_reg;
        done_next   = done_reg;
        found_next  = found_reg;
        value_next  = value_reg;

        if (pos_reg < 4'(FIND_LEN))
        begin
            disc_next = disc_reg && (c == find_char(pos_reg[2:0]));
        end
        else
        begin
            disc_next = 1'b0;
        end

        if (pos_reg == 4'd0)
        begin
            if (c == CH_QUERY)
            begin
                tok_next    = tok_reg + 1'b1;
                kidx_next   = 4'd0;
                kmatch_next = '1;
                acc_next    = '0;
                done_next   = 1'b0;
            end
        end
        else if (tok_reg != '0 && !stop_reg)
        begin
            if (is_alnum(c))
            begin
                if (tok_reg[0])
                begin
                    for (int k = 0; k < NUM_KEYS; k++)
                    begin
                        if (key_char(3'(k), kidx_reg) != c)
                        begin
                            kmatch_next[k] = 1'b0;
                        end
                    end
                    if (kidx_reg != 4'hF)
                    begin
                        kidx_next = kidx_reg + 1'b1;
                    end
                end
                else if (!done_reg)
                begin
                    if (is_digit(c))
                    begin
                        acc_next = (prod[VALUE_BITS+3:VALUE_BITS] != 4'd0)
                                 ? VALUE_MAX : prod[VALUE_BITS-1:0];
                    end
                    else
                    begin
                        done_next = 1'b1;
                    end
                end
            end
            else
            begin
                // close the current token
                if (tok_reg[0])
                begin
                    active_next = KEY_NONE;
                    for (int k = 0; k < NUM_KEYS; k++)
                    begin
                        if (kmatch_reg[k] && KEY_LEN[k] == kidx_reg && !found_reg[k])
                        begin
                            found_next[k] = 1'b1;
                            value_next[k] = '0;
                            active_next   = 3'(k);
                        end
                    end
                end
                else if (active_reg != KEY_NONE)
                begin
                    value_next[active_reg] = acc_reg;
                end

                if (is_delim(c) && tok_reg < TOK_LIMIT)
                begin
                    tok_next    = tok_reg + 1'b1;
                    kidx_next   = 4'd0;
                    kmatch_next = '1;
                    acc_next    = '0;
                    done_next   = 1'b0;
                end
                else
                begin
                    stop_next = 1'b1;
                end
            end
        end

        if (pos_reg != 4'hF)
        begin
            pos_next = pos_reg + 1'b1;
        end
    end

    assign found_word = disc_next && (pos_reg == 4'(FIND_LEN - 1));

    // An open value token still owes its value at the end; an open key token
    // leaves its value at zero, which it already holds.
    always_comb
    begin
        final_val = value_next;
        if (tok_next != '0 && !stop_next && !tok_next[0] && active_next != KEY_NONE)
        begin
            final_val[active_next] = acc_next;
        end
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            wide_val[k] = 32'(final_val[k]);
        end
    end

    always_comb
    begin
        result = '0;
        result.packet_kind = KIND_IGNORED;
        if (tok_next != '0)
        begin
            result.received_pin = wide_val[K_PIN][15:0];
            if (wide_val[K_PIN] == 32'(access_pin))
            begin
                result.packet_kind      = KIND_APPLIED;
                result.effect_number    = wide_val[K_EFFECT][15:0];
                result.brightness_level = wide_val[K_BRIGHT][15:0];
                result.variable_zero    = wide_val[K_VAR0][15:0];
                result.variable_one     = wide_val[K_VAR1][15:0];
                result.variable_two     = wide_val[K_VAR2][15:0];
                result.save_request     = (final_val[K_SAVE] == VALUE_BITS'(1));
            end
            else
            begin
                result.packet_kind = KIND_REJECTED;
            end
        end
        else if (found_word)
        begin
            result.packet_kind = KIND_DISCOVERY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= 4'd0;
            disc_reg   <= 1'b1;
            tok_reg    <= '0;
            stop_reg   <= 1'b0;
            kidx_reg   <= 4'd0;
            kmatch_reg <= '1;
            active_reg <= KEY_NONE;
            acc_reg    <= '0;
            done_reg   <= 1'b0;
            found_reg  <= '0;
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                value_reg[k] <= '0;
            end
        end
        else if (step)
        begin
            if (beat.last_byte)
            begin
                // drop all packet state ready for the next packet
                pos_reg    <= 4'd0;
                disc_reg   <= 1'b1;
                tok_reg    <= '0;
                stop_reg   <= 1'b0;
                kidx_reg   <= 4'd0;
                kmatch_reg <= '1;
                active_reg <= KEY_NONE;
                acc_reg    <= '0;
                done_reg   <= 1'b0;
                found_reg  <= '0;
                for (int k = 0; k < NUM_KEYS; k++)
                begin
                    value_reg[k] <= '0;
                end
            end
            else
            begin
                pos_reg    <= pos_next;
                disc_reg   <= disc_next;
                tok_reg    <= tok_next;
                stop_reg   <= stop_next;
                kidx_reg   <= kidx_next;
                kmatch_reg <= kmatch_next;
                active_reg <= active_next;
                acc_reg    <= acc_next;
                done_reg   <= done_next;
                found_reg  <= found_next;
                value_reg  <= value_next;
            end
        end
    end

endmodule
`default_nettype wire

// ===== hdl/query_string_command_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// query_string_command_parser
// Streaming parser for query-string command packets, one byte per beat.
// ----------------------------------------------------------------------------
// Packet bytes enter one per cycle with no gaps needed, one beat per clock
// when both sides keep up; the rate is set by the per-byte update of the
// tokeniser state that every byte passes through. A byte is held in an input
// register and then applied to the parser state (non-final bytes never wait);
// and on the last byte of a packet the verdict is captured in the result
// register once the result slot is free, giving one result beat. Other bytes
// produce no result. The access pin is written through the cfg channel, which
// is always ready, and should only be changed between packets.
module query_string_command_parser
    import qscp_pkg::*;
#(
    parameter int MAX_PAIRS  = 7,
    parameter int VALUE_BITS = 16
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    qscp_stream_if.sink   cfg,
    qscp_stream_if.sink   packet,
    qscp_stream_if.source verdict
);

    logic        in_valid_reg, in_valid_next;
    qscp_in_t    in_data_reg;
    logic        out_valid_reg, out_valid_next;
    qscp_out_t   out_data_reg;
    qscp_out_t   parse_result;
    logic [15:0] access_pin_reg;
    logic        slot_free;
    logic        advance;

    assign cfg.ready = 1'b1;

    // A non-final byte never waits on the result side.
    assign slot_free    = !out_valid_reg || verdict.ready;
    assign advance      = in_valid_reg && (!in_data_reg.last_byte || slot_free);
    assign packet.ready = !in_valid_reg || advance;

    assign in_valid_next  = packet.ready ? packet.valid : in_valid_reg;
    assign out_valid_next = (advance && in_data_reg.last_byte) ? 1'b1
                          : (verdict.ready ? 1'b0 : out_valid_reg);

    assign verdict.valid = out_valid_reg;
    assign verdict.data  = out_data_reg;

    qscp_parser #(
        .MAX_PAIRS  (MAX_PAIRS),
        .VALUE_BITS (VALUE_BITS)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .beat       (in_data_reg),
        .access_pin (access_pin_reg),
        .result     (parse_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            access_pin_reg <= 16'd0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                access_pin_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (packet.valid && packet.ready)
        begin
            in_data_reg <= packet.data;
        end
        if (advance && in_data_reg.last_byte)
        begin
            out_data_reg <= parse_result;
        end
    end

`ifndef SYNTH
    a_result_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_data_reg.last_byte |=> out_valid_reg)
        else $error("last byte did not produce a result beat");

    a_no_result_mid_packet: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance && in_data_reg.last_byte))
        else $error("result beat without a last byte");

    a_save_only_applied: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.save_request |->
            out_data_reg.packet_kind == KIND_APPLIED)
        else $error("save request on a packet that was not applied");

    a_quiet_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_data_reg.packet_kind == KIND_IGNORED ||
                          out_data_reg.packet_kind == KIND_DISCOVERY) |->
            out_data_reg.received_pin == 16'd0 && out_data_reg.effect_number == 16'd0)
        else $error("non-query result carries parsed fields");
`endif

endmodule
`default_nettype wire
